>>> hdl/dda_pkg.sv
// Package for the DDA line rasterizer: widths, transaction structs,
// controller states and the command/status bundles between the units.
// Depends on nothing; every other file imports it.
package dda_pkg;

    // Coordinate and fixed point widths.
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    // Major axis position, minor accumulator and slope widths.
    localparam int POS_W = COORD_BITS + 1;
    localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

    // Slope divider: dividend and quotient width, step counter width.
    localparam int DIV_W = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Transaction kinds on the input channel.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  point_valid;
        logic                  last_point;
    } t_out_item;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_DIVIDE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic div_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_needs_div;
        logic div_last;
    } t_dp_status;

endpackage

>>> hdl/dda_ctrl.sv
// Controller for the DDA line rasterizer: handshakes and divide sequencing.
// Depends on dda_pkg.
module dda_ctrl
    import dda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_kind,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_fire;

    // Input is taken when idle and the output register is free or draining.
    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_fire  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fire && (i_kind == KIND_LOAD) && i_status.load_needs_div) begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_fire && (i_kind == KIND_LOAD);
                o_cmd.step = w_fire && (i_kind == KIND_NEXT);
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output register occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire && (i_kind == KIND_NEXT)) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/dda_datapath.sv
// Datapath for the DDA line rasterizer: line setup, restoring slope divider,
// major/minor stepping and the output register.
// Depends on dda_pkg.
module dda_datapath
    import dda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_item
);

    // Line state.
    logic                    r_active;
    logic                    r_step_on_y;
    logic [POS_W-1:0]        r_pos;
    logic [POS_W-1:0]        r_limit;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_slope;

    // Divider state.
    logic [COORD_BITS-1:0]   r_rem;
    logic [DIV_W-1:0]        r_quo;
    logic [COORD_BITS-1:0]   r_den;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;

    t_out_item               r_out;

    // Setup signals.
    logic signed [POS_W-1:0] w_dx;
    logic signed [POS_W-1:0] w_dy;
    logic                    w_vert;
    logic                    w_horz;
    logic                    w_step_on_y;
    logic [POS_W-1:0]        w_start;
    logic [POS_W-1:0]        w_end;
    logic [COORD_BITS-1:0]   w_minor0;
    logic signed [POS_W-1:0] w_num;
    logic signed [POS_W-1:0] w_den;
    logic [COORD_BITS-1:0]   w_num_abs;
    logic [COORD_BITS-1:0]   w_den_abs;

    // Divider step signals.
    logic [COORD_BITS:0]     w_trial;
    logic [COORD_BITS-1:0]   w_diff;
    logic                    w_ge;
    logic [COORD_BITS-1:0]   n_rem;
    logic [DIV_W-1:0]        n_quo;
    logic [ACC_W-1:0]        w_slope_mag;
    logic [ACC_W-1:0]        n_slope;

    // Step signals.
    logic                    w_emit;
    logic                    w_last;
    logic [COORD_BITS-1:0]   w_minor;
    logic [COORD_BITS-1:0]   w_major;

    // Endpoint differences and case selection for a load.
    assign w_dx = $signed({1'b0, i_item.x_end}) - $signed({1'b0, i_item.x_start});
    assign w_dy = $signed({1'b0, i_item.y_end}) - $signed({1'b0, i_item.y_start});
    assign w_vert = (w_dx == '0);
    assign w_horz = (w_dy == '0);
    assign w_step_on_y = w_vert || (!w_horz && !(w_dy <= w_dx));

    assign w_start  = w_step_on_y ? {1'b0, i_item.y_start} : {1'b0, i_item.x_start};
    assign w_end    = w_step_on_y ? {1'b0, i_item.y_end} : {1'b0, i_item.x_end};
    assign w_minor0 = w_step_on_y ? i_item.x_start : i_item.y_start;

    // Slope operands as magnitudes; the sign is applied after the divide.
    assign w_num     = w_step_on_y ? w_dx : w_dy;
    assign w_den     = w_step_on_y ? w_dy : w_dx;
    assign w_num_abs = w_num[POS_W-1] ? COORD_BITS'(-w_num) : COORD_BITS'(w_num);
    assign w_den_abs = w_den[POS_W-1] ? COORD_BITS'(-w_den) : COORD_BITS'(w_den);

    assign o_status.load_needs_div = !w_vert && !w_horz;
    assign o_status.div_last       = (r_cnt == CNT_W'(1));

    // One restoring division step: one quotient bit per cycle.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = COORD_BITS'(w_trial - {1'b0, r_den});
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_ge ? w_diff : w_trial[COORD_BITS-1:0];
    assign n_quo   = {r_quo[DIV_W-2:0], w_ge};

    // Truncation toward zero: divide magnitudes, then restore the sign.
    assign w_slope_mag = {2'b00, n_quo};
    assign n_slope     = r_neg ? (~w_slope_mag + ACC_W'(1)) : w_slope_mag;

    // Pixel for a next request.
    assign w_emit  = r_active && (r_pos <= r_limit);
    assign w_last  = (r_pos == r_limit);
    assign w_minor = r_acc[ACC_W-1] ? '0 : r_acc[FRAC_BITS +: COORD_BITS];
    assign w_major = r_pos[COORD_BITS-1:0];

    // Line activity flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_active <= (w_end >= w_start);
        end else if (i_cmd.step) begin
            r_active <= w_emit && !w_last;
        end
    end

    // Line geometry, accumulator and slope.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_on_y <= 1'b0;
            r_pos       <= '0;
            r_limit     <= '0;
            r_acc       <= '0;
            r_slope     <= '0;
        end else if (i_cmd.load) begin
            r_step_on_y <= w_step_on_y;
            r_pos       <= w_start;
            r_limit     <= w_end;
            r_acc       <= $signed({2'b00, w_minor0, {FRAC_BITS{1'b0}}});
            r_slope     <= '0;
        end else if (i_cmd.div_step && o_status.div_last) begin
            r_slope <= $signed(n_slope);
        end else if (i_cmd.step && w_emit && !w_last) begin
            r_pos <= r_pos + POS_W'(1);
            r_acc <= r_acc + r_slope;
        end
    end

    // Divider registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= {w_num_abs, {FRAC_BITS{1'b0}}};
            r_den <= w_den_abs;
            r_neg <= w_num[POS_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Output register, loaded on every next request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (w_emit) begin
                r_out.point_x     <= r_step_on_y ? w_minor : w_major;
                r_out.point_y     <= r_step_on_y ? w_major : w_minor;
                r_out.point_valid <= 1'b1;
                r_out.last_point  <= w_last;
            end else begin
                r_out.point_x     <= '0;
                r_out.point_y     <= '0;
                r_out.point_valid <= 1'b0;
                r_out.last_point  <= 1'b1;
            end
        end
    end

    assign o_item = r_out;

endmodule

>>> hdl/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasterizer: joins the controller and datapath.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
//
// A load transaction (kind 0) latches two endpoints and produces no output;
// a next transaction (kind 1) produces one point per transaction, with
// last_point set on the final pixel and point_valid low once no pixel is
// left. Next transactions are taken one per cycle while the unit is idle
// and the output is accepted; their results sit in an output register, so
// a new transaction is taken while the previous point drains. A load of a
// vertical or horizontal line needs no divide. For a load of a sloped line
// the slope comes from a restoring divider that produces one quotient bit
// per cycle, and no transaction is taken until it finishes.
// Lines whose stepped coordinate decreases load as empty.
module dda_line_rasterizer_unit
    import dda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Handshake and sequencing control.
    dda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_item.kind),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Line state, divider and output register.
    dda_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_item   (o_item)
    );

endmodule
